/* hw/rtl/ubc_pkg.sv */
package ubc_pkg;

  localparam int CpW = 25;
  localparam int CatW = 8;
  localparam int BlockCount = 250;
  localparam int IdxW = 8;

  localparam logic [CatW-1:0] CatFullwidthAlnum = 8'hFE;
  localparam logic [CatW-1:0] CatHalfwidthKana = 8'hFF;

  typedef logic [CpW-1:0] cp_t;
  typedef logic [CatW-1:0] cat_t;

  typedef struct packed {
    logic alnum;
    logic kana;
  } special_t;

  localparam cp_t BlockStart [BlockCount] = '{
    25'h0000, 25'h0080, 25'h0100, 25'h0180, 25'h0250, 25'h02B0, 25'h0300, 25'h0370,
    25'h0400, 25'h0500, 25'h0530, 25'h0590, 25'h0600, 25'h0700, 25'h0750, 25'h0780,
    25'h07C0, 25'h0800, 25'h0840, 25'h08A0, 25'h0900, 25'h0980, 25'h0A00, 25'h0A80,
    25'h0B00, 25'h0B80, 25'h0C00, 25'h0C80, 25'h0D00, 25'h0D80, 25'h0E00, 25'h0E80,
    25'h0F00, 25'h1000, 25'h10A0, 25'h1100, 25'h1200, 25'h1380, 25'h13A0, 25'h1400,
    25'h1680, 25'h16A0, 25'h1700, 25'h1720, 25'h1740, 25'h1760, 25'h1780, 25'h1800,
    25'h18B0, 25'h1900, 25'h1950, 25'h1980, 25'h19E0, 25'h1A00, 25'h1A20, 25'h1B00,
    25'h1B80, 25'h1BC0, 25'h1C00, 25'h1C50, 25'h1CC0, 25'h1CD0, 25'h1D00, 25'h1D80,
    25'h1DC0, 25'h1E00, 25'h1F00, 25'h2000, 25'h2070, 25'h20A0, 25'h20D0, 25'h2100,
    25'h2150, 25'h2190, 25'h2200, 25'h2300, 25'h2400, 25'h2440, 25'h2460, 25'h2500,
    25'h2580, 25'h25A0, 25'h2600, 25'h2700, 25'h27C0, 25'h27F0, 25'h2800, 25'h2900,
    25'h2980, 25'h2A00, 25'h2B00, 25'h2C00, 25'h2C60, 25'h2C80, 25'h2D00, 25'h2D30,
    25'h2D80, 25'h2DE0, 25'h2E00, 25'h2E80, 25'h2F00, 25'h2FF0, 25'h3000, 25'h3040,
    25'h30A0, 25'h3100, 25'h3130, 25'h3190, 25'h31A0, 25'h31C0, 25'h31F0, 25'h3200,
    25'h3300, 25'h3400, 25'h4DC0, 25'h4E00, 25'hA000, 25'hA490, 25'hA4D0, 25'hA500,
    25'hA640, 25'hA6A0, 25'hA700, 25'hA720, 25'hA800, 25'hA830, 25'hA840, 25'hA880,
    25'hA8E0, 25'hA900, 25'hA930, 25'hA960, 25'hA980, 25'hAA00, 25'hAA60, 25'hAA80,
    25'hAAE0, 25'hAB00, 25'hABC0, 25'hAC00, 25'hD7B0, 25'hD800, 25'hDB80, 25'hDC00,
    25'hE000, 25'hF900, 25'hFB00, 25'hFB50, 25'hFE00, 25'hFE10, 25'hFE20, 25'hFE30,
    25'hFE50, 25'hFE70, 25'hFF00, 25'hFFF0, 25'h10000, 25'h10080, 25'h10100, 25'h10140,
    25'h10190, 25'h101D0, 25'h10280, 25'h102A0, 25'h10300, 25'h10330, 25'h10380,
    25'h103A0, 25'h10400, 25'h10450, 25'h10480, 25'h10800, 25'h10840, 25'h10900,
    25'h10920, 25'h10980, 25'h109A0, 25'h10A00, 25'h10A60, 25'h10B00, 25'h10B40,
    25'h10B60, 25'h10C00, 25'h10E60, 25'h11000, 25'h11080, 25'h110D0, 25'h11100,
    25'h11180, 25'h11680, 25'h12000, 25'h12400, 25'h13000, 25'h16800, 25'h16F00,
    25'h1B000, 25'h1D000, 25'h1D100, 25'h1D200, 25'h1D300, 25'h1D360, 25'h1D400,
    25'h1EE00, 25'h1F000, 25'h1F030, 25'h1F0A0, 25'h1F100, 25'h1F200, 25'h1F300,
    25'h1F600, 25'h1F680, 25'h1F700, 25'h20000, 25'h2A700, 25'h2B740, 25'h2F800,
    25'h30000, 25'h40000, 25'h50000, 25'h60000, 25'h70000, 25'h80000, 25'h90000,
    25'hA0000, 25'hB0000, 25'hC0000, 25'hD0000, 25'hE0000, 25'hE0100, 25'hF0000,
    25'h100000, 25'h110000, 25'h120000, 25'h130000, 25'h140000, 25'h150000,
    25'h160000, 25'h170000, 25'h180000, 25'h190000, 25'h1A0000, 25'h1B0000,
    25'h1C0000, 25'h1D0000, 25'h1E0000, 25'h1F0000, 25'h200000, 25'h210000,
    25'h220000, 25'h1000000
  };

endpackage

/* hw/rtl/ubc_if.sv */
interface ubc_cp_if;
  import ubc_pkg::*;
  logic valid;
  logic ready;
  cp_t code_point;
  modport source (output valid, output code_point, input ready);
  modport sink (input valid, input code_point, output ready);
endinterface

interface ubc_cat_if;
  import ubc_pkg::*;
  logic valid;
  logic ready;
  cat_t category;
  modport source (output valid, output category, input ready);
  modport sink (input valid, input category, output ready);
endinterface

/* hw/rtl/ubc_classify.sv */
module ubc_classify
  import ubc_pkg::*;
(
  input  cp_t  cp,
  output cat_t cat
);

  logic [IdxW-1:0] idx;
  special_t sp;

  always_comb begin
    sp.alnum = (cp inside {[25'hFF10:25'hFF19], [25'hFF21:25'hFF3A], [25'hFF41:25'hFF5A]});
    sp.kana = (cp inside {[25'hFF66:25'hFF6F], [25'hFF71:25'hFF9D]});
  end

  // The table ascends, so the index is the last start not above the code point.
  always_comb begin
    idx = '0;
    for (int i = 1; i < BlockCount; i++) begin
      if (cp >= BlockStart[i]) idx = IdxW'(i);
    end
  end

  always_comb begin
    if (sp.alnum) cat = CatFullwidthAlnum;
    else if (sp.kana) cat = CatHalfwidthKana;
    else cat = cat_t'(idx);
  end

endmodule

/* hw/rtl/unicode_block_classifier.sv */
// Channel  Direction  Payload
// in_      input      code_point, 25 bits
// out_     output     category, 8 bits
//
// One item per cycle while the output is not stalled; a result appears in the cycle after its item is taken.
// The result is held in a single register after the comparator bank.
// Reset empties the result register; there is no other state.
// The input stalls only while the result register is full and not taken.
module unicode_block_classifier
  import ubc_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  ubc_cp_if.sink  in_ch,
  ubc_cat_if.source out_ch
);

  logic valid_r;
  logic valid_nxt;
  cat_t cat_r;
  cat_t cat_nxt;
  logic take;

  ubc_classify u_classify (
    .cp  (in_ch.code_point),
    .cat (cat_nxt)
  );

  assign in_ch.ready = !valid_r || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign valid_nxt = take || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cat_r <= cat_nxt;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.category = cat_r;

`ifndef SYNTH
  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> valid_r && cat_r == $past(cat_nxt))
    else $error("Result register missed an item.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ch.ready |=> valid_r && $stable(cat_r))
    else $error("Stalled result changed.");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> cat_r < 8'd250 || cat_r == CatFullwidthAlnum || cat_r == CatHalfwidthKana)
    else $error("Category out of range.");
`endif

endmodule

/* verif/ubc_checker.sv */
module ubc_checker
  import ubc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic cp_valid,
  input logic cp_ready,
  input cp_t cp_data,
  input logic cat_valid,
  input logic cat_ready,
  input cat_t cat_data,
  output int fail_count,
  output int pending,
  output int cat_count
);

  // Block starts, kept apart from the package so the prediction stands alone.
  logic [24:0] starts [250];
  cat_t expected_cats [$];

  initial begin
    logic [24:0] tail [26];
    logic [24:0] head [216];
    head = '{
      'h0000, 'h0080, 'h0100, 'h0180, 'h0250, 'h02B0, 'h0300, 'h0370,
      'h0400, 'h0500, 'h0530, 'h0590, 'h0600, 'h0700, 'h0750, 'h0780,
      'h07C0, 'h0800, 'h0840, 'h08A0, 'h0900, 'h0980, 'h0A00, 'h0A80,
      'h0B00, 'h0B80, 'h0C00, 'h0C80, 'h0D00, 'h0D80, 'h0E00, 'h0E80,
      'h0F00, 'h1000, 'h10A0, 'h1100, 'h1200, 'h1380, 'h13A0, 'h1400,
      'h1680, 'h16A0, 'h1700, 'h1720, 'h1740, 'h1760, 'h1780, 'h1800,
      'h18B0, 'h1900, 'h1950, 'h1980, 'h19E0, 'h1A00, 'h1A20, 'h1B00,
      'h1B80, 'h1BC0, 'h1C00, 'h1C50, 'h1CC0, 'h1CD0, 'h1D00, 'h1D80,
      'h1DC0, 'h1E00, 'h1F00, 'h2000, 'h2070, 'h20A0, 'h20D0, 'h2100,
      'h2150, 'h2190, 'h2200, 'h2300, 'h2400, 'h2440, 'h2460, 'h2500,
      'h2580, 'h25A0, 'h2600, 'h2700, 'h27C0, 'h27F0, 'h2800, 'h2900,
      'h2980, 'h2A00, 'h2B00, 'h2C00, 'h2C60, 'h2C80, 'h2D00, 'h2D30,
      'h2D80, 'h2DE0, 'h2E00, 'h2E80, 'h2F00, 'h2FF0, 'h3000, 'h3040,
      'h30A0, 'h3100, 'h3130, 'h3190, 'h31A0, 'h31C0, 'h31F0, 'h3200,
      'h3300, 'h3400, 'h4DC0, 'h4E00, 'hA000, 'hA490, 'hA4D0, 'hA500,
      'hA640, 'hA6A0, 'hA700, 'hA720, 'hA800, 'hA830, 'hA840, 'hA880,
      'hA8E0, 'hA900, 'hA930, 'hA960, 'hA980, 'hAA00, 'hAA60, 'hAA80,
      'hAAE0, 'hAB00, 'hABC0, 'hAC00, 'hD7B0, 'hD800, 'hDB80, 'hDC00,
      'hE000, 'hF900, 'hFB00, 'hFB50, 'hFE00, 'hFE10, 'hFE20, 'hFE30,
      'hFE50, 'hFE70, 'hFF00, 'hFFF0, 'h10000, 'h10080, 'h10100, 'h10140,
      'h10190, 'h101D0, 'h10280, 'h102A0, 'h10300, 'h10330, 'h10380, 'h103A0,
      'h10400, 'h10450, 'h10480, 'h10800, 'h10840, 'h10900, 'h10920, 'h10980,
      'h109A0, 'h10A00, 'h10A60, 'h10B00, 'h10B40, 'h10B60, 'h10C00, 'h10E60,
      'h11000, 'h11080, 'h110D0, 'h11100, 'h11180, 'h11680, 'h12000, 'h12400,
      'h13000, 'h16800, 'h16F00, 'h1B000, 'h1D000, 'h1D100, 'h1D200, 'h1D300,
      'h1D360, 'h1D400, 'h1EE00, 'h1F000, 'h1F030, 'h1F0A0, 'h1F100, 'h1F200,
      'h1F300, 'h1F600, 'h1F680, 'h1F700, 'h20000, 'h2A700, 'h2B740, 'h2F800
    };
    tail = '{
      'h30000, 'h40000, 'h50000, 'h60000, 'h70000, 'h80000, 'h90000, 'hA0000,
      'hB0000, 'hC0000, 'hD0000, 'hE0000, 'hE0100, 'hF0000, 'h100000, 'h110000,
      'h120000, 'h130000, 'h140000, 'h150000, 'h160000, 'h170000, 'h180000,
      'h190000, 'h1A0000, 'h1B0000
    };
    for (int i = 0; i < 216; i++) starts[i] = head[i];
    for (int i = 0; i < 26; i++) starts[216 + i] = tail[i];
    starts[242] = 'h1C0000;
    starts[243] = 'h1D0000;
    starts[244] = 'h1E0000;
    starts[245] = 'h1F0000;
    starts[246] = 'h200000;
    starts[247] = 'h210000;
    starts[248] = 'h220000;
    starts[249] = 'h1000000;
  end

  function automatic cat_t classify(cp_t cp);
    int hits;
    hits = 0;
    if ((cp >= 'hFF10 && cp <= 'hFF19) || (cp >= 'hFF21 && cp <= 'hFF3A) ||
        (cp >= 'hFF41 && cp <= 'hFF5A)) begin
      return CatFullwidthAlnum;
    end
    if ((cp >= 'hFF66 && cp <= 'hFF6F) || (cp >= 'hFF71 && cp <= 'hFF9D)) begin
      return CatHalfwidthKana;
    end
    for (int i = 0; i < 250; i++) begin
      if (starts[i] <= cp) hits++;
    end
    return cat_t'(hits - 1);
  endfunction

  assign pending = expected_cats.size();

  initial begin
    fail_count = 0;
    cat_count = 0;
  end

  always @(posedge clk) begin
    cat_t want;
    if (rst_n && cat_valid && cat_ready) begin
      cat_count++;
      if (expected_cats.size() == 0) begin
        $error("category: unexpected item, actual %0d", cat_data);
        fail_count++;
      end else begin
        want = expected_cats.pop_front();
        if (cat_data !== want) begin
          $error("category: expected %0d, actual %0d", want, cat_data);
          fail_count++;
        end
      end
    end
    if (rst_n && cp_valid && cp_ready) expected_cats.push_back(classify(cp_data));
  end

endmodule

/* verif/testbench.sv */
module testbench;
  import ubc_pkg::*;

  logic clk;
  logic rst_n;
  int fail_count;
  int pending;
  int cat_count;
  int cycles;
  bit stim_done;
  bit long_hold;

  ubc_cp_if cp_ch ();
  ubc_cat_if cat_ch ();

  unicode_block_classifier uut (
    .clk(clk), .rst_n(rst_n), .in_ch(cp_ch.sink), .out_ch(cat_ch.source)
  );

  ubc_checker check (
    .clk(clk), .rst_n(rst_n),
    .cp_valid(cp_ch.valid), .cp_ready(cp_ch.ready), .cp_data(cp_ch.code_point),
    .cat_valid(cat_ch.valid), .cat_ready(cat_ch.ready), .cat_data(cat_ch.category),
    .fail_count(fail_count), .pending(pending), .cat_count(cat_count)
  );

  initial clk = 0;
  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cp_t pick_cp();
    int r;
    r = $urandom_range(99);
    if (r < 30) return cp_t'($urandom_range('hFFFF));
    if (r < 45) return cp_t'($urandom_range('hFF00, 'hFFFF));
    if (r < 65) return cp_t'($urandom_range('h10000, 'h10FFFF));
    if (r < 80) return cp_t'($urandom_range('h110000, 'hFFFFFF));
    if (r < 88) return cp_t'($urandom_range('hFFFFF0, 'h100000F));
    return cp_t'($urandom());
  endfunction

  task automatic send(cp_t cp);
    cp_ch.valid <= 1'b1;
    cp_ch.code_point <= cp;
    @(posedge clk);
    while (!cp_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_gapped(cp_t cp);
    int g;
    g = gap_len();
    if (g > 0) begin
      cp_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    send(cp);
  endtask

  // Receiver: random stalls, with one long hold during which the input is held off.
  initial begin
    int g;
    cat_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        cat_ch.ready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold = 0;
      end
      g = (stim_done || cycles % 2000 < 300) ? 0 : gap_len();
      if (g > 0) begin
        cat_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        cat_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    cp_t directed [$];
    rst_n = 1'b0;
    cp_ch.valid = 1'b0;
    cp_ch.code_point = '0;
    stim_done = 0;
    long_hold = 0;
    directed = '{
      'h0, 'h7F, 'h80, 'hFF0F, 'hFF10, 'hFF19, 'hFF1A, 'hFF21, 'hFF3A, 'hFF41,
      'hFF5A, 'hFF65, 'hFF66, 'hFF6F, 'hFF70, 'hFF71, 'hFF9D, 'hFF9E, 'hFFFF,
      'h10FFFF, 'h110000, 'hFFFFFF, 'h1000000, 'h1FFFFFF, 'h1555555
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (directed[i]) send(directed[i]);
    long_hold = 1;
    for (int i = 0; i < 1425; i++) begin
      if (i < 100 || $urandom_range(3) == 0) send(pick_cp());
      else send_gapped(pick_cp());
    end
    cp_ch.valid <= 1'b0;
    stim_done = 1;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Classified %0d code points: block edges, fullwidth and halfwidth ranges,",
             cat_count);
    $display("out-of-range values and a long output stall with the input held off.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
